// ===== hw/rtl/prq_pkg.sv =====
// Shared types, codes and default sizes for the priority ready queue scheduler.
package prq_pkg;

	localparam int LEVELS_DEF      = 32;
	localparam int MAX_THREADS_DEF = 64;

	localparam int ID_W   = 6;
	localparam int PRIO_W = 5;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_READY  = 2'd0,
		CMD_SCHED  = 2'd1,
		CMD_RETIRE = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_NONE   = 2'd1,
		STAT_BAD_ID = 2'd2,
		STAT_RSVD   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APP_RD,
		ST_APP_WR,
		ST_POP_RD,
		ST_POP_ID,
		ST_LVL_RD,
		ST_LVL_GET,
		ST_UNL_RD,
		ST_UNL_WR,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/prq_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module prq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/prq_penc.sv =====
// Priority encoder: finds the highest set bit of the ready level bitmap.
module prq_penc #(
	parameter int LEVELS = prq_pkg::LEVELS_DEF
) (
	input  logic [LEVELS-1:0]         ready,
	output logic                      any,
	output logic [$clog2(LEVELS)-1:0] top
);

	always_comb begin
		any = 1'b0;
		top = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (ready[l]) begin
				any = 1'b1;
				top = $clog2(LEVELS)'(l);
			end
		end
	end

endmodule

// ===== hw/rtl/priority_ready_queue_scheduler.sv =====
// Thread scheduler with one FIFO ready queue per priority level; the queues are
// doubly linked lists held in head, tail, next, prev and level RAMs, a flop
// bitmap marks non-empty levels and a priority encoder picks the top one.
// Commands are taken one at a time. Rejected commands and retire go to the
// result directly, make ready appends, remove reads the level then unlinks,
// and a schedule that switches threads appends the outgoing thread, reads
// the head and reads and writes back the links; list steps wait on RAM reads.
// One result per command shows the active thread afterwards; the next command
// is accepted while a result still waits in the output register.
module priority_ready_queue_scheduler #(
	parameter int LEVELS      = prq_pkg::LEVELS_DEF,
	parameter int MAX_THREADS = prq_pkg::MAX_THREADS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [prq_pkg::CMD_W-1:0]   command,
	input  logic [prq_pkg::ID_W-1:0]    thread_id,
	input  logic [prq_pkg::PRIO_W-1:0]  priority_req,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [prq_pkg::ID_W-1:0]    active_id,
	output logic                        active_valid,
	output logic [prq_pkg::STAT_W-1:0]  status
);

	localparam int LW = $clog2(LEVELS);
	localparam int TW = $clog2(MAX_THREADS);

	prq_pkg::state_t  state_q, state_d;
	prq_pkg::cmd_t    cmd_q;
	prq_pkg::status_t status_q;

	logic [TW-1:0]          id_q, cur_q;
	logic [LW-1:0]          lvl_q, top_q, cur_lvl_q;
	logic                   cur_valid_q;
	logic [LEVELS-1:0]      ready_q;
	logic [MAX_THREADS-1:0] queued_q;

	logic                     out_valid_q, out_act_valid_q;
	logic [prq_pkg::ID_W-1:0] out_id_q;
	prq_pkg::status_t         out_status_q;

	// RAM ports
	logic          head_we, tail_we, next_we, prev_we, tl_we;
	logic [LW-1:0] head_wa, tail_wa, head_ra;
	logic [TW-1:0] head_wd, tail_wd, head_rd, tail_rd;
	logic [TW-1:0] next_wa, next_wd, next_rd, prev_wa, prev_wd, prev_rd;
	logic [LW-1:0] tl_rd;

	logic          any_ready;
	logic [LW-1:0] top_lvl;

	logic          accept, id_ok, ready_reject, sched_stay, is_head, is_tail;
	logic [TW-1:0] id_in;
	logic [LW-1:0] prio_clamped;
	prq_pkg::cmd_t cmd_in;

	prq_penc #(.LEVELS(LEVELS)) u_penc (
		.ready (ready_q),
		.any   (any_ready),
		.top   (top_lvl)
	);

	prq_ram #(.WIDTH(TW), .DEPTH(LEVELS)) u_head (
		.clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
		.raddr(head_ra), .rdata(head_rd)
	);

	prq_ram #(.WIDTH(TW), .DEPTH(LEVELS)) u_tail (
		.clk(clk), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd),
		.raddr(lvl_q), .rdata(tail_rd)
	);

	prq_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(id_q), .rdata(next_rd)
	);

	prq_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(id_q), .rdata(prev_rd)
	);

	prq_ram #(.WIDTH(LW), .DEPTH(MAX_THREADS)) u_level (
		.clk(clk), .we(tl_we), .waddr(id_q), .wdata(lvl_q),
		.raddr(id_q), .rdata(tl_rd)
	);

	assign in_stall = (state_q != prq_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign cmd_in   = prq_pkg::cmd_t'(command);
	assign id_ok    = (11'(thread_id) < 11'(MAX_THREADS));
	assign id_in    = TW'(thread_id);

	assign prio_clamped = (7'(priority_req) > 7'(LEVELS - 1)) ? LW'(LEVELS - 1)
	                                                         : LW'(priority_req);

	assign ready_reject = !id_ok || queued_q[id_in] || (cur_valid_q && cur_q == id_in);
	assign sched_stay   = cur_valid_q && (!any_ready || top_lvl < cur_lvl_q);

	assign is_head = (head_rd == id_q);
	assign is_tail = (tail_rd == id_q);

	assign out_valid    = out_valid_q;
	assign active_id    = out_id_q;
	assign active_valid = out_act_valid_q;
	assign status       = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM write controls
	always_comb begin
		state_d = state_q;
		head_we = 1'b0; head_wa = lvl_q; head_wd = id_q;
		tail_we = 1'b0; tail_wa = lvl_q; tail_wd = id_q;
		next_we = 1'b0; next_wa = tail_rd; next_wd = id_q;
		prev_we = 1'b0; prev_wa = id_q;    prev_wd = tail_rd;
		tl_we   = 1'b0;
		head_ra = (state_q == prq_pkg::ST_POP_RD) ? top_q : lvl_q;
		unique case (state_q)
			prq_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd_in)
						prq_pkg::CMD_READY:
							state_d = ready_reject ? prq_pkg::ST_DONE : prq_pkg::ST_APP_RD;
						prq_pkg::CMD_SCHED: begin
							if (sched_stay || !any_ready) begin
								state_d = prq_pkg::ST_DONE;
							end else if (cur_valid_q) begin
								state_d = prq_pkg::ST_APP_RD;
							end else begin
								state_d = prq_pkg::ST_POP_RD;
							end
						end
						prq_pkg::CMD_RETIRE: state_d = prq_pkg::ST_DONE;
						prq_pkg::CMD_REMOVE:
							state_d = (!id_ok || !queued_q[id_in]) ? prq_pkg::ST_DONE
							                                       : prq_pkg::ST_LVL_RD;
						default: state_d = prq_pkg::ST_DONE;
					endcase
				end
			end
			prq_pkg::ST_APP_RD: state_d = prq_pkg::ST_APP_WR;
			prq_pkg::ST_APP_WR: begin
				// link behind the old tail, or open an empty level
				if (ready_q[lvl_q]) begin
					next_we = 1'b1;
					prev_we = 1'b1;
				end else begin
					head_we = 1'b1;
				end
				tail_we = 1'b1;
				tl_we   = 1'b1;
				state_d = (cmd_q == prq_pkg::CMD_SCHED) ? prq_pkg::ST_POP_RD
				                                        : prq_pkg::ST_DONE;
			end
			prq_pkg::ST_POP_RD:  state_d = prq_pkg::ST_POP_ID;
			prq_pkg::ST_POP_ID:  state_d = prq_pkg::ST_UNL_RD;
			prq_pkg::ST_LVL_RD:  state_d = prq_pkg::ST_LVL_GET;
			prq_pkg::ST_LVL_GET: state_d = prq_pkg::ST_UNL_RD;
			prq_pkg::ST_UNL_RD:  state_d = prq_pkg::ST_UNL_WR;
			prq_pkg::ST_UNL_WR: begin
				priority if (is_head && is_tail) begin
				end else if (is_head) begin
					head_we = 1'b1;
					head_wd = next_rd;
				end else if (is_tail) begin
					tail_we = 1'b1;
					tail_wd = prev_rd;
				end else begin
					// bridge the neighbours around the thread
					next_we = 1'b1;
					next_wa = prev_rd;
					next_wd = next_rd;
					prev_we = 1'b1;
					prev_wa = next_rd;
					prev_wd = prev_rd;
				end
				state_d = prq_pkg::ST_DONE;
			end
			prq_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = prq_pkg::ST_IDLE;
				end
			end
			default: state_d = prq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q     <= 1'b0;
			cur_q           <= '0;
			ready_q         <= '0;
			queued_q        <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if (state_q == prq_pkg::ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				prq_pkg::ST_IDLE: begin
					if (accept && cmd_in == prq_pkg::CMD_RETIRE) begin
						cur_valid_q <= 1'b0;
					end
				end
				prq_pkg::ST_APP_WR: begin
					ready_q[lvl_q] <= 1'b1;
					queued_q[id_q] <= 1'b1;
				end
				prq_pkg::ST_UNL_WR: begin
					if (is_head && is_tail) begin
						ready_q[lvl_q] <= 1'b0;
					end
					queued_q[id_q] <= 1'b0;
					if (cmd_q == prq_pkg::CMD_SCHED) begin
						cur_q       <= id_q;
						cur_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			prq_pkg::ST_IDLE: begin
				if (accept) begin
					cmd_q    <= cmd_in;
					status_q <= prq_pkg::STAT_OK;
					unique case (cmd_in)
						prq_pkg::CMD_READY: begin
							id_q  <= id_in;
							lvl_q <= prio_clamped;
							if (ready_reject) begin
								status_q <= prq_pkg::STAT_BAD_ID;
							end
						end
						prq_pkg::CMD_SCHED: begin
							top_q <= top_lvl;
							id_q  <= cur_q;
							lvl_q <= cur_lvl_q;
							if (!sched_stay && !any_ready) begin
								status_q <= prq_pkg::STAT_NONE;
							end
						end
						prq_pkg::CMD_RETIRE: begin
							if (!cur_valid_q) begin
								status_q <= prq_pkg::STAT_NONE;
							end
						end
						prq_pkg::CMD_REMOVE: begin
							id_q <= id_in;
							if (!id_ok || !queued_q[id_in]) begin
								status_q <= prq_pkg::STAT_BAD_ID;
							end
						end
						default: begin
						end
					endcase
				end
			end
			prq_pkg::ST_POP_ID: begin
				id_q  <= head_rd;
				lvl_q <= top_q;
			end
			prq_pkg::ST_LVL_GET: lvl_q <= tl_rd;
			prq_pkg::ST_UNL_WR: begin
				if (cmd_q == prq_pkg::CMD_SCHED) begin
					cur_lvl_q <= lvl_q;
				end
			end
			prq_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_id_q        <= cur_valid_q ? prq_pkg::ID_W'(cur_q) : '0;
					out_act_valid_q <= cur_valid_q;
					out_status_q    <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/priority_ready_queue_scheduler_test.sv =====
// Self-checking testbench for the priority ready queue scheduler.
`timescale 1ns / 1ps

class sched_scoreboard;
	logic [prq_pkg::ID_W-1:0]   head_mem [32];
	logic [prq_pkg::ID_W-1:0]   tail_mem [32];
	logic [prq_pkg::ID_W-1:0]   next_mem [64];
	logic [prq_pkg::ID_W-1:0]   prev_mem [64];
	logic [prq_pkg::PRIO_W-1:0] lvl_mem  [64];
	bit                         queued   [64];
	logic [31:0]                ready_map;
	logic [prq_pkg::ID_W-1:0]   cur_id;
	bit                         cur_on;
	logic [prq_pkg::ID_W+2:0]   pending_q [$];
	int                         errors;

	function new();
		ready_map = '0;
		cur_id = '0;
		cur_on = 0;
		errors = 0;
		foreach (queued[i]) queued[i] = 0;
	endfunction

	function int top_level();
		for (int l = 31; l >= 0; l--)
			if (ready_map[l]) return l;
		return -1;
	endfunction

	function void enqueue_thread(logic [prq_pkg::ID_W-1:0] id,
	                             logic [prq_pkg::PRIO_W-1:0] lvl);
		if (ready_map[lvl]) begin
			next_mem[tail_mem[lvl]] = id;
			prev_mem[id] = tail_mem[lvl];
		end else begin
			head_mem[lvl] = id;
			ready_map[lvl] = 1'b1;
		end
		tail_mem[lvl] = id;
		queued[id] = 1;
	endfunction

	function void dequeue_thread(logic [prq_pkg::ID_W-1:0] id);
		logic [prq_pkg::PRIO_W-1:0] lvl;
		bit at_head, at_tail;
		lvl = lvl_mem[id];
		at_head = head_mem[lvl] == id;
		at_tail = tail_mem[lvl] == id;
		if (at_head && at_tail) ready_map[lvl] = 1'b0;
		else if (at_head) head_mem[lvl] = next_mem[id];
		else if (at_tail) tail_mem[lvl] = prev_mem[id];
		else begin
			next_mem[prev_mem[id]] = next_mem[id];
			prev_mem[next_mem[id]] = prev_mem[id];
		end
		queued[id] = 0;
	endfunction

	function void note_command(prq_pkg::cmd_t cmd, logic [prq_pkg::ID_W-1:0] id,
	                           logic [prq_pkg::PRIO_W-1:0] prio);
		prq_pkg::status_t st;
		int top;
		logic [prq_pkg::ID_W-1:0] nid;
		st = prq_pkg::STAT_OK;
		unique case (cmd)
			prq_pkg::CMD_READY: begin
				if (queued[id] || (cur_on && cur_id == id)) st = prq_pkg::STAT_BAD_ID;
				else begin
					lvl_mem[id] = prio;
					enqueue_thread(id, prio);
				end
			end
			prq_pkg::CMD_SCHED: begin
				top = top_level();
				if (cur_on && (top < 0 || top < lvl_mem[cur_id])) st = prq_pkg::STAT_OK;
				else if (top < 0) st = prq_pkg::STAT_NONE;
				else begin
					if (cur_on) enqueue_thread(cur_id, lvl_mem[cur_id]);
					nid = head_mem[top];
					dequeue_thread(nid);
					cur_id = nid;
					cur_on = 1;
				end
			end
			prq_pkg::CMD_RETIRE: begin
				if (cur_on) cur_on = 0;
				else st = prq_pkg::STAT_NONE;
			end
			prq_pkg::CMD_REMOVE: begin
				if (!queued[id]) st = prq_pkg::STAT_BAD_ID;
				else dequeue_thread(id);
			end
		endcase
		pending_q.push_back({cur_on ? cur_id : 6'd0, cur_on, st});
	endfunction

	function void check_result(logic [prq_pkg::ID_W-1:0] id, logic on,
	                           logic [prq_pkg::STAT_W-1:0] st);
		logic [prq_pkg::ID_W+2:0] exp_r;
		if (pending_q.size() == 0) begin
			$error("result with nothing expected: id=%0d valid=%0d status=%0d", id, on, st);
			errors++;
			return;
		end
		exp_r = pending_q.pop_front();
		if (exp_r[8:3] !== id) begin
			$error("active_id: expected %0d, got %0d", exp_r[8:3], id);
			errors++;
		end
		if (exp_r[2] !== on) begin
			$error("active_valid: expected %0d, got %0d", exp_r[2], on);
			errors++;
		end
		if (exp_r[1:0] !== st) begin
			$error("status: expected %0d, got %0d", exp_r[1:0], st);
			errors++;
		end
	endfunction
endclass

module priority_ready_queue_scheduler_test;
	logic                         clk = 0;
	logic                         arst_n = 0;
	logic                         in_valid = 0;
	logic                         in_stall;
	logic [prq_pkg::CMD_W-1:0]    command = '0;
	logic [prq_pkg::ID_W-1:0]     thread_id = '0;
	logic [prq_pkg::PRIO_W-1:0]   priority_req = '0;
	logic                         out_valid;
	logic                         out_stall = 0;
	logic [prq_pkg::ID_W-1:0]     active_id;
	logic                         active_valid;
	logic [prq_pkg::STAT_W-1:0]   status;

	sched_scoreboard sb = new();
	int send_idle = 0;
	int recv_stall = 0;
	longint cycles = 0;

	priority_ready_queue_scheduler dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("FAIL");
			$finish;
		end
		if (arst_n && out_valid && !out_stall)
			sb.check_result(active_id, active_valid, status);
		if (arst_n && in_valid && !in_stall)
			sb.note_command(prq_pkg::cmd_t'(command), thread_id, priority_req);
	end

	// Receiver stall, redrawn each falling edge.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall);

	// Hold the item until taken; the next call idles or replaces it, and drain() lowers valid.
	task automatic issue(prq_pkg::cmd_t cmd, int id, int prio);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		thread_id <= prq_pkg::ID_W'(id);
		priority_req <= prq_pkg::PRIO_W'(prio);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending_q.size() != 0) @(negedge clk);
	endtask

	// Random traffic: ready random threads, schedule, occasional retire or remove.
	task automatic random_command();
		int r;
		int id;
		r = $urandom_range(99);
		id = $urandom_range(63);
		if (r < 8) id = ($urandom_range(3) << 4) | (id & 3);
		if (r < 40) issue(prq_pkg::CMD_READY, id,
		                  (r < 10) ? $urandom_range(3) + 28 : $urandom_range(31));
		else if (r < 75) issue(prq_pkg::CMD_SCHED, id, $urandom_range(31));
		else if (r < 87) issue(prq_pkg::CMD_RETIRE, id, $urandom_range(31));
		else issue(prq_pkg::CMD_REMOVE, id, $urandom_range(31));
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: empty cases, extremes, pre-emption, unlink middle/head/tail.
		issue(prq_pkg::CMD_SCHED, 0, 0);
		issue(prq_pkg::CMD_RETIRE, 0, 0);
		issue(prq_pkg::CMD_REMOVE, 63, 31);
		issue(prq_pkg::CMD_READY, 63, 31);
		issue(prq_pkg::CMD_READY, 63, 0);
		issue(prq_pkg::CMD_READY, 0, 0);
		issue(prq_pkg::CMD_READY, 1, 0);
		issue(prq_pkg::CMD_READY, 2, 0);
		issue(prq_pkg::CMD_READY, 3, 0);
		issue(prq_pkg::CMD_REMOVE, 2, 0);
		issue(prq_pkg::CMD_REMOVE, 0, 0);
		issue(prq_pkg::CMD_REMOVE, 3, 0);
		issue(prq_pkg::CMD_SCHED, 0, 0);
		issue(prq_pkg::CMD_READY, 63, 5);
		issue(prq_pkg::CMD_SCHED, 0, 0);
		issue(prq_pkg::CMD_SCHED, 0, 0);
		issue(prq_pkg::CMD_READY, 42, 31);
		issue(prq_pkg::CMD_SCHED, 0, 0);
		issue(prq_pkg::CMD_RETIRE, 0, 0);
		issue(prq_pkg::CMD_SCHED, 0, 0);
		issue(prq_pkg::CMD_RETIRE, 0, 0);
		issue(prq_pkg::CMD_SCHED, 0, 0);
		issue(prq_pkg::CMD_RETIRE, 0, 0);
		issue(prq_pkg::CMD_SCHED, 0, 0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 65) : 0;
			recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 32 : 65) : 0;
			for (int i = 0; i < 220; i++) random_command();
			drain();
		end
		send_idle = 0;
		recv_stall = 0;
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
